// ===== hw/rtl/mq_pkg.sv =====
// Max-queue package: command codes and sequencer state type.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package mq_pkg;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_ROTATE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} mq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_with_max_priority_tracking.sv =====
// Max queue top level: ring-buffer FIFO of (value, priority) entries with top tracking.
// Depends on mq_pkg and mq_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Command channel: a beat (command, value, priority_req) is taken at a rising
//   edge with start high and busy low. Commands: push, pop front, rotate front
//   entry to back; the unused code is a no-op that just reports state.
// - Result channel: done pulses for one cycle; all result ports are valid in
//   that cycle only. The receiver cannot stall, so nothing is held back.
// - Sequencing: push, no-op, and pop/rotate on an empty or single-entry queue
//   stay in idle (done the cycle after the beat). Any other pop or rotate
//   reads the new front from the entry RAM in SCAN, then passes FIN before
//   done; when the removed entry was the top, SCAN reads all N entries left
//   after removal, one entry per cycle through the RAM's single read port.
// - busy is high from a beat that enters SCAN until its done cycle; one beat is in
//   work at a time, and the next beat can be taken at the end of done.
// - Reset clears head, tail, count and the sequencer; the RAM is not cleared,
//   only entries that are held are ever read.
// - Front, back and top entries are kept in registers so every result is
//   reported without extra RAM reads; the RAM holds the queue body.
module fifo_with_max_priority_tracking #(
	parameter int DEPTH         = 64,
	parameter int VALUE_BITS    = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 command,
	input  wire logic [VALUE_BITS-1:0]      value,
	input  wire logic [PRIORITY_BITS-1:0]   priority_req,
	output logic                            done,
	output logic                            pop_valid,
	output logic [VALUE_BITS-1:0]           popped_value,
	output logic [PRIORITY_BITS-1:0]        popped_priority,
	output logic [VALUE_BITS-1:0]           front_value,
	output logic [PRIORITY_BITS-1:0]        front_priority,
	output logic [VALUE_BITS-1:0]           back_value,
	output logic [PRIORITY_BITS-1:0]        back_priority,
	output logic [VALUE_BITS-1:0]           top_value,
	output logic [PRIORITY_BITS-1:0]        top_priority,
	output logic [$clog2(DEPTH+1)-1:0]      entry_count,
	output logic                            is_empty,
	output logic                            push_dropped
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = VALUE_BITS + PRIORITY_BITS;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_COUNT  = CW'(1);
	localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		next_slot = (i == LAST_SLOT) ? '0 : i + AW'(1);
	endfunction

	mq_pkg::mq_state_t state_q, state_d;

	// ring pointers and count
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	// cached entries
	logic [AW-1:0]            top_idx_q;
	logic [VALUE_BITS-1:0]    top_val_q, front_val_q, back_val_q, popped_val_q;
	logic [PRIORITY_BITS-1:0] top_pri_q, front_pri_q, back_pri_q, popped_pri_q;

	// result flags
	logic pop_valid_q, dropped_q, done_q;

	// rescan control
	logic          scan_q, rot_q, first_q;
	logic [AW-1:0] rot_slot_q, scan_addr_q;
	logic [CW-1:0] issue_left_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [VALUE_BITS-1:0]    rd_val;
	logic [PRIORITY_BITS-1:0] rd_pri;

	logic accept, full, is_push, is_pop, is_rot, was_top, issue;

	assign busy    = (state_q != mq_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign full    = (count_q == FULL_COUNT);
	assign is_push = (command == mq_pkg::CMD_PUSH);
	assign is_pop  = (command == mq_pkg::CMD_POP);
	assign is_rot  = (command == mq_pkg::CMD_ROTATE);
	assign was_top = (head_q == top_idx_q);
	assign issue   = (state_q == mq_pkg::ST_SCAN) && (issue_left_q != '0);

	// at most one write per beat: push stores the new entry, rotate stores the old front
	assign ram_we    = accept && ((is_push && !full) || (is_rot && count_q != '0));
	assign ram_waddr = tail_q;
	assign ram_wdata = is_push ? {value, priority_req} : {front_val_q, front_pri_q};
	assign rd_val    = ram_rdata[EW-1:PRIORITY_BITS];
	assign rd_pri    = ram_rdata[PRIORITY_BITS-1:0];

	mq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mq_pkg::ST_IDLE: begin
				if (accept && (is_pop || is_rot) && count_q > ONE_COUNT) begin
					state_d = mq_pkg::ST_SCAN;
				end
			end
			mq_pkg::ST_SCAN: begin
				// last read was issued the cycle before; its data lands now
				if (issue_left_q == '0) begin
					state_d = mq_pkg::ST_FIN;
				end
			end
			mq_pkg::ST_FIN: begin
				state_d = mq_pkg::ST_IDLE;
			end
			default: begin
				state_d = mq_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			top_idx_q    <= '0;
			done_q       <= 1'b0;
			pop_valid_q  <= 1'b0;
			dropped_q    <= 1'b0;
			scan_q       <= 1'b0;
			rot_q        <= 1'b0;
			first_q      <= 1'b0;
			rot_slot_q   <= '0;
			issue_left_q <= '0;
			rd_vld_s1    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			if (accept) begin
				pop_valid_q <= 1'b0;
				dropped_q   <= 1'b0;
				if (is_push) begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						tail_q  <= next_slot(tail_q);
						count_q <= count_q + ONE_COUNT;
						if (count_q == '0 || top_pri_q < priority_req) begin
							top_idx_q <= tail_q;
						end
					end
					done_q <= 1'b1;
				end else if (is_pop || is_rot) begin
					if (count_q != '0) begin
						pop_valid_q  <= 1'b1;
						head_q       <= next_slot(head_q);
						scan_q       <= was_top;
						rot_q        <= is_rot;
						rot_slot_q   <= tail_q;
						first_q      <= 1'b1;
						issue_left_q <= was_top ? count_q - ONE_COUNT : ONE_COUNT;
						if (is_rot) begin
							tail_q <= next_slot(tail_q);
						end else begin
							count_q <= count_q - ONE_COUNT;
						end
						if (count_q == ONE_COUNT) begin
							// single entry: rotate keeps it as the top
							if (is_rot) begin
								top_idx_q <= tail_q;
							end
							done_q <= 1'b1;
						end
					end else begin
						done_q <= 1'b1;
					end
				end else begin
					done_q <= 1'b1;
				end
			end
			if (issue) begin
				issue_left_q <= issue_left_q - ONE_COUNT;
			end
			if (rd_vld_s1) begin
				first_q <= 1'b0;
				if (scan_q && (first_q || top_pri_q < rd_pri)) begin
					top_idx_q <= rd_idx_s1;
				end
			end
			if (state_q == mq_pkg::ST_FIN) begin
				// re-appended entry wins only on a strictly higher priority
				if (rot_q && top_pri_q < popped_pri_q) begin
					top_idx_q <= rot_slot_q;
				end
				done_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			scan_addr_q <= next_slot(scan_addr_q);
			rd_idx_s1   <= scan_addr_q;
		end
		if (accept) begin
			scan_addr_q <= next_slot(head_q);
			if (is_push && !full) begin
				back_val_q <= value;
				back_pri_q <= priority_req;
				if (count_q == '0) begin
					front_val_q <= value;
					front_pri_q <= priority_req;
				end
				if (count_q == '0 || top_pri_q < priority_req) begin
					top_val_q <= value;
					top_pri_q <= priority_req;
				end
			end else if ((is_pop || is_rot) && count_q != '0) begin
				popped_val_q <= front_val_q;
				popped_pri_q <= front_pri_q;
				if (is_rot) begin
					back_val_q <= front_val_q;
					back_pri_q <= front_pri_q;
					if (count_q == ONE_COUNT) begin
						top_val_q <= front_val_q;
						top_pri_q <= front_pri_q;
					end
				end
			end
		end
		if (rd_vld_s1) begin
			if (first_q) begin
				front_val_q <= rd_val;
				front_pri_q <= rd_pri;
			end
			if (scan_q && (first_q || top_pri_q < rd_pri)) begin
				top_val_q <= rd_val;
				top_pri_q <= rd_pri;
			end
		end
		if (state_q == mq_pkg::ST_FIN && rot_q && top_pri_q < popped_pri_q) begin
			top_val_q <= popped_val_q;
			top_pri_q <= popped_pri_q;
		end
	end

	// result ports: cached entries, zeroed when absent
	assign done            = done_q;
	assign pop_valid       = pop_valid_q;
	assign popped_value    = pop_valid_q ? popped_val_q : '0;
	assign popped_priority = pop_valid_q ? popped_pri_q : '0;
	assign is_empty        = (count_q == '0);
	assign entry_count     = count_q;
	assign front_value     = is_empty ? '0 : front_val_q;
	assign front_priority  = is_empty ? '0 : front_pri_q;
	assign back_value      = is_empty ? '0 : back_val_q;
	assign back_priority   = is_empty ? '0 : back_pri_q;
	assign top_value       = is_empty ? '0 : top_val_q;
	assign top_priority    = is_empty ? '0 : top_pri_q;
	assign push_dropped    = dropped_q;

endmodule

`default_nettype wire
